// ===== sv/hid_single_key_report_fsm_unit_assert.svh =====
// Assertion macros for the single-key HID report unit.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef HID_SINGLE_KEY_REPORT_FSM_UNIT_ASSERT_SVH
`define HID_SINGLE_KEY_REPORT_FSM_UNIT_ASSERT_SVH

// same-cycle implication
`define HSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hsk_pkg.sv =====
// Package of the single-key HID report unit: word types, command codes,
// report layout and the key lookup table. No dependencies.
`default_nettype none

package hsk_pkg;

  localparam int unsigned NumKeys   = 16;
  localparam int unsigned TableSize = 16;
  localparam int unsigned ReportLen = 8;
  localparam int unsigned IdxW      = $clog2(ReportLen);
  localparam int unsigned ModIdx    = 0;
  localparam int unsigned UsageIdx  = 2;
  localparam int unsigned LookupLen = (NumKeys < TableSize) ? NumKeys : TableSize;

  typedef enum logic [2:0] {
    CMD_KEY_DOWN  = 3'd0,
    CMD_KEY_UP    = 3'd1,
    CMD_POLL      = 3'd2,
    CMD_READ      = 3'd3,
    CMD_XFER_DONE = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] key_char;
    logic       endpoint_busy;
  } in_word_t;

  typedef struct packed {
    logic [7:0] report_byte;
    logic       request_transfer;
    logic       last_of_run;
  } out_word_t;

  // run handed from the control stage to the emitter
  typedef struct packed {
    logic       valid;
    logic       is_read;
    logic       req;
    logic [7:0] modifier;
    logic [7:0] usage;
  } run_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] usage;
  } key_code_t;

  localparam logic [7:0] CharTab [TableSize] = '{
    8'h1B, 8'h30, 8'h0D, 8'h2B,
    8'h31, 8'h32, 8'h33, 8'h2D,
    8'h34, 8'h35, 8'h36, 8'h2A,
    8'h37, 8'h38, 8'h39, 8'h25
  };

  localparam logic [7:0] ModRShift = 8'h20;

  localparam logic [7:0] ModTab [TableSize] = '{
    8'h00, 8'h00, 8'h00, ModRShift,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, ModRShift,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] UsageTab [TableSize] = '{
    8'h29, 8'h27, 8'h28, 8'h57,
    8'h1E, 8'h1F, 8'h20, 8'h56,
    8'h21, 8'h22, 8'h23, 8'h55,
    8'h24, 8'h25, 8'h26, 8'h54
  };

  // first match wins; unknown keys give zero codes
  function automatic key_code_t key_lookup(logic [7:0] c);
    key_code_t res;
    res = '0;
    for (int i = int'(LookupLen) - 1; i >= 0; i--) begin
      if (CharTab[i] == c) begin
        res.modifier = ModTab[i];
        res.usage    = UsageTab[i];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/hid_single_key_report_fsm_unit.sv =====
// Top level of the single-key HID keyboard report unit.
// Depends on hsk_pkg, hsk_ctrl, hsk_emit and the assertion macro header.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+---------------------
//   in      | input     | in_valid_i / in_stall_o | hsk_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i | hsk_pkg::out_word_t
//
// Key down, key up and transfer done give no output word; poll gives one word;
// read report gives eight words, one per cycle while out_stall_i is low, counted by
// the emitter's byte counter. The first word passes the input register, then the emitter's valid register.
// Reset clears the key flags and both valid registers; no clearing pass.
// Output stall backs up into in_stall_o only once the input register is full.
`default_nettype none

module hid_single_key_report_fsm_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hsk_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hsk_pkg::out_word_t      out_word_o
);
  import hsk_pkg::*;

`include "hid_single_key_report_fsm_unit_assert.svh"

  run_t run;
  logic emit_free;

  hsk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .emit_free_i (emit_free),
    .run_o       (run)
  );

  hsk_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_i       (run),
    .emit_free_o (emit_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  `HSK_ASSERT_NOW(a_load_when_free, run.valid, emit_free, "run loaded into busy emitter")
  `HSK_ASSERT_NOW(a_poll_word, out_valid_o && out_word_o.request_transfer,
    out_word_o.last_of_run && out_word_o.report_byte == 8'h00, "bad poll word")
  `HSK_ASSERT_NXT(a_run_continues, out_valid_o && !out_stall_i && !out_word_o.last_of_run,
    out_valid_o, "report run broken")
  `HSK_ASSERT_NXT(a_run_ends, out_valid_o && !out_stall_i && out_word_o.last_of_run
    && !run.valid, !out_valid_o, "word repeated after last")

endmodule

`default_nettype wire

// ===== sv/hsk_ctrl.sv =====
// Control stage: input register, key state flags and command decode.
// Depends on hsk_pkg; hands one run per poll or read word to hsk_emit.
`default_nettype none

module hsk_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire hsk_pkg::in_word_t in_word_i,
  input  wire logic            emit_free_i,
  output hsk_pkg::run_t        run_o
);
  import hsk_pkg::*;

  logic      in_valid_q, in_valid_d;
  in_word_t  in_q;
  logic [7:0] held_key_q, held_key_d;
  logic      down_q, down_d;
  logic      up_q, up_d;
  logic      busy_q, busy_d;
  logic      advance, accept;
  key_code_t code;

  assign advance    = in_valid_q & emit_free_i;
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;
  assign code       = key_lookup(held_key_q);

  always_comb begin
    in_valid_d = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    held_key_d = held_key_q;
    down_d     = down_q;
    up_d       = up_q;
    busy_d     = busy_q;
    run_o      = '0;
    if (advance) begin
      case (in_q.cmd)
        CMD_KEY_DOWN: begin
          if (!in_q.endpoint_busy && !busy_q) begin
            held_key_d = in_q.key_char;
            busy_d     = 1'b1;
            down_d     = 1'b1;
            up_d       = 1'b0;
          end
        end
        CMD_KEY_UP: begin
          if (busy_q && held_key_q == in_q.key_char) begin
            up_d = 1'b1;
          end
        end
        CMD_POLL: begin
          run_o.valid = 1'b1;
          run_o.req   = down_q | up_q;
        end
        CMD_READ: begin
          run_o.valid    = 1'b1;
          run_o.is_read  = 1'b1;
          run_o.modifier = down_q ? code.modifier : 8'h00;
          run_o.usage    = down_q ? code.usage : 8'h00;
        end
        CMD_XFER_DONE: begin
          if (down_q) begin
            down_d = 1'b0;
          end else if (up_q) begin
            up_d   = 1'b0;
            busy_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      held_key_q <= '0;
      down_q     <= 1'b0;
      up_q       <= 1'b0;
      busy_q     <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      held_key_q <= held_key_d;
      down_q     <= down_d;
      up_q       <= up_d;
      busy_q     <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hsk_emit.sv =====
// Emitter: holds one run and streams its words through the output register.
// Depends on hsk_pkg; fed by hsk_ctrl.
`default_nettype none

module hsk_emit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hsk_pkg::run_t run_i,
  output logic               emit_free_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output hsk_pkg::out_word_t out_word_o
);
  import hsk_pkg::*;

  logic            valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            is_read_q;
  logic            req_q;
  logic [7:0]      mod_q;
  logic [7:0]      usage_q;
  logic            take, last;

  assign last        = ~is_read_q | (idx_q == IdxW'(ReportLen - 1));
  assign take        = valid_q & ~out_stall_i;
  assign emit_free_o = ~valid_q | (take & last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (run_i.valid) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_comb begin
    out_word_o = '0;
    out_word_o.request_transfer = ~is_read_q & req_q;
    out_word_o.last_of_run      = last;
    if (is_read_q) begin
      if (idx_q == IdxW'(ModIdx)) begin
        out_word_o.report_byte = mod_q;
      end else if (idx_q == IdxW'(UsageIdx)) begin
        out_word_o.report_byte = usage_q;
      end
    end
  end

  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_i.valid) begin
      is_read_q <= run_i.is_read;
      req_q     <= run_i.req;
      mod_q     <= run_i.modifier;
      usage_q   <= run_i.usage;
    end
  end

endmodule

`default_nettype wire

// ===== bench/hid_single_key_report_fsm_unit_test.sv =====
// Self-checking bench for hid_single_key_report_fsm_unit: directed and random
// key sessions with idle gaps on both channels. Depends on hsk_pkg and the RTL.
`default_nettype none

module hid_single_key_report_fsm_unit_test;
  import hsk_pkg::*;

  localparam int unsigned NUM_KEYS     = 16;
  localparam int unsigned REPORT_BYTES = 8;
  localparam int unsigned MOD_BYTE     = 0;
  localparam int unsigned USAGE_BYTE   = 2;
  localparam int unsigned RANDOM_ITEMS = 288;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;
  localparam logic [7:0]  RSHIFT        = 8'h20;

  localparam logic [7:0] key_chars [16] = '{
    8'h1B, 8'h30, 8'h0D, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h2D,
    8'h34, 8'h35, 8'h36, 8'h2A, 8'h37, 8'h38, 8'h39, 8'h25
  };
  localparam logic [7:0] key_mods [16] = '{
    8'h00, 8'h00, 8'h00, RSHIFT, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, RSHIFT, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] key_usages [16] = '{
    8'h29, 8'h27, 8'h28, 8'h57, 8'h1E, 8'h1F, 8'h20, 8'h56,
    8'h21, 8'h22, 8'h23, 8'h55, 8'h24, 8'h25, 8'h26, 8'h54
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // predicted key state
  logic [7:0] held_key = 8'h00;
  logic       down_pend = 1'b0;
  logic       up_pend = 1'b0;
  logic       key_busy = 1'b0;

  out_word_t report_words_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  hid_single_key_report_fsm_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // updates the key state and queues the expected words
  function automatic void predict_hid_word(in_word_t w);
    logic [7:0] modc;
    logic [7:0] usec;
    out_word_t  o;
    modc = 8'h00;
    usec = 8'h00;
    case (w.cmd)
      CMD_KEY_DOWN:
        if (!w.endpoint_busy && !key_busy) begin
          held_key = w.key_char;
          key_busy = 1'b1;
          down_pend = 1'b1;
          up_pend = 1'b0;
        end
      CMD_KEY_UP:
        if (key_busy && held_key == w.key_char) begin
          up_pend = 1'b1;
        end
      CMD_POLL: begin
        o.report_byte = 8'h00;
        o.request_transfer = down_pend || up_pend;
        o.last_of_run = 1'b1;
        report_words_q.push_back(o);
      end
      CMD_READ: begin
        if (down_pend)
          for (int s = 0; s < NUM_KEYS && s < 16; s++)
            if (key_chars[s] == held_key) begin
              modc = key_mods[s];
              usec = key_usages[s];
              break;
            end
        for (int k = 0; k < REPORT_BYTES; k++) begin
          o.report_byte = (k == MOD_BYTE) ? modc : (k == USAGE_BYTE) ? usec : 8'h00;
          o.request_transfer = 1'b0;
          o.last_of_run = (k == REPORT_BYTES - 1);
          report_words_q.push_back(o);
        end
      end
      CMD_XFER_DONE:
        if (down_pend) begin
          down_pend = 1'b0;
        end else if (up_pend) begin
          up_pend = 1'b0;
          key_busy = 1'b0;
        end
      default: ;
    endcase
  endfunction

  // starts and ends at a rising edge
  task automatic send_word(input logic [2:0] cmd, input logic [7:0] key, input logic ep);
    int unsigned gap;
    logic        stalled;
    in_word_t    w;
    gap = pick_gap();
    w.cmd = cmd;
    w.key_char = key;
    w.endpoint_busy = ep;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    predict_hid_word(w);
    sent_cnt++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (report_words_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (no_idle) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_left <= pick_gap();
    end
  end

  task automatic note_mismatch(input string what, input out_word_t exp, input out_word_t act);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch (%s): exp byte %h req %b last %b, got byte %h req %b last %b",
               what, exp.report_byte, exp.request_transfer, exp.last_of_run,
               act.report_byte, act.request_transfer, act.last_of_run);
  endtask

  always @(negedge clk_i) begin : check_words
    out_word_t exp;
    if (rst_ni && out_valid && !out_stall) begin
      if (report_words_q.size() == 0) begin
        note_mismatch("unexpected word", '0, out_word);
      end else begin
        exp = report_words_q.pop_front();
        if (exp.report_byte !== out_word.report_byte ||
            exp.request_transfer !== out_word.request_transfer ||
            exp.last_of_run !== out_word.last_of_run)
          note_mismatch("field", exp, out_word);
      end
    end
  end

  task automatic test_idle_reports();
    send_word(CMD_POLL, 8'h00, 1'b0);
    send_word(CMD_READ, 8'hFF, 1'b1);
    send_word(CMD_XFER_DONE, 8'h00, 1'b0);
    send_word(CMD_KEY_UP, 8'h00, 1'b0);
  endtask

  task automatic test_press_release_cycle();
    send_word(CMD_KEY_DOWN, 8'h2B, 1'b1);   // endpoint busy: refused
    send_word(CMD_POLL, 8'h00, 1'b0);
    send_word(CMD_KEY_DOWN, 8'h2B, 1'b0);
    send_word(CMD_KEY_DOWN, 8'h1B, 1'b0);   // key busy: refused
    send_word(CMD_POLL, 8'h00, 1'b1);
    send_word(CMD_READ, 8'h00, 1'b0);
    send_word(CMD_KEY_UP, 8'h1B, 1'b0);     // other key
    send_word(CMD_XFER_DONE, 8'h00, 1'b0);
    send_word(CMD_POLL, 8'h00, 1'b0);
    send_word(CMD_READ, 8'h00, 1'b0);
    send_word(CMD_KEY_UP, 8'h2B, 1'b1);
    send_word(CMD_POLL, 8'h00, 1'b0);
    send_word(CMD_XFER_DONE, 8'hFF, 1'b1);
  endtask

  task automatic test_unknown_and_unused();
    send_word(CMD_KEY_DOWN, 8'hFF, 1'b0);   // not in table
    send_word(CMD_READ, 8'h00, 1'b0);
    send_word(CMD_KEY_UP, 8'hFF, 1'b0);     // up while down still pending
    send_word(CMD_XFER_DONE, 8'h00, 1'b0);
    send_word(CMD_XFER_DONE, 8'h00, 1'b0);
    for (logic [3:0] c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
      send_word(c[2:0], 8'hFF, 1'b1);
    send_word(CMD_KEY_DOWN, 8'h25, 1'b0);
    send_word(CMD_READ, 8'h00, 1'b0);
    send_word(CMD_XFER_DONE, 8'h00, 1'b0);
  endtask

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_chars[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic random_session();
    logic [7:0] key;
    key = pick_key();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4))
        send_word(3'($urandom_range(0, CMD_UNUSED_HI)), rnd_byte(), rnd_bit());
      return;
    end
    send_word(CMD_KEY_DOWN, key, $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) != 0) send_word(CMD_POLL, rnd_byte(), rnd_bit());
    if ($urandom_range(0, 9) != 0) send_word(CMD_READ, rnd_byte(), rnd_bit());
    if ($urandom_range(0, 3) == 0) send_word(CMD_KEY_UP, key, rnd_bit());
    if ($urandom_range(0, 9) != 0) send_word(CMD_XFER_DONE, rnd_byte(), rnd_bit());
    if ($urandom_range(0, 9) != 0)
      send_word(CMD_KEY_UP, ($urandom_range(0, 5) == 0) ? pick_key() : key, rnd_bit());
    if ($urandom_range(0, 9) != 0) send_word(CMD_POLL, rnd_byte(), rnd_bit());
    if ($urandom_range(0, 4) == 0) send_word(CMD_READ, rnd_byte(), rnd_bit());
    if ($urandom_range(0, 9) != 0) send_word(CMD_XFER_DONE, rnd_byte(), rnd_bit());
  endtask

  task automatic test_random_sessions(input int unsigned count);
    int unsigned start;
    start = sent_cnt;
    while (sent_cnt - start < count) random_session();
  endtask

  task automatic test_drain_pause();
    random_session();
    wait_drained();
    random_session();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (6) random_session();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_reports();
    test_press_release_cycle();
    test_unknown_and_unused();
    test_random_sessions(RANDOM_ITEMS / 2);
    test_drain_pause();
    test_back_to_back();
    test_random_sessions(RANDOM_ITEMS / 2);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && report_words_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/hsk_pkg.sv
sv/hsk_ctrl.sv
sv/hsk_emit.sv
sv/hid_single_key_report_fsm_unit.sv
bench/hid_single_key_report_fsm_unit_test.sv
